### design/yuvq_pkg.sv
`default_nettype none
package yuvq_pkg;

    // field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int OP_W     = SAMPLE_W + 2;
    localparam int COEF_W   = 17;
    localparam int PROD_W   = OP_W + 1 + COEF_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int PIX_W    = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SELECT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_INPUT    = 4'd1;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [2:0][COEF_W-1:0]   t_coef_row;
    typedef logic [2:0][2:0][COEF_W-1:0] t_matrix;

    typedef logic [3:0][2:0][SAMPLE_W-1:0] t_quad;

    // operands handed from the input stage to the weighting units
    typedef struct packed {
        logic [3:0][2:0][OP_W-1:0] luma;
        logic [2:0][OP_W-1:0]      chroma;
    } t_quad_ops;

    // q16 matrices, rows y, u, v and columns r, g, b
    localparam t_matrix MATRIX_601 = '{
        '{-17'sd6554,  -17'sd33750, 17'sd40304},
        '{17'sd28573,  -17'sd18930, -17'sd9642},
        '{17'sd7471,   17'sd38469,  17'sd19595}
    };
    localparam t_matrix MATRIX_709 = '{
        '{-17'sd3695,  -17'sd36609, 17'sd40304},
        '{17'sd28573,  -17'sd22025, -17'sd6547},
        '{17'sd4731,   17'sd46871,  17'sd13932}
    };

endpackage
`default_nettype wire

### design/yuvq_front.sv
`default_nettype none
module yuvq_front (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic              i_wide,
    input  wire yuvq_pkg::t_quad   i_quad,
    output yuvq_pkg::t_quad_ops    o_ops
);
    import yuvq_pkg::*;

    t_quad r_quad;
    t_quad n_masked;
    logic [2:0][OP_W-1:0] n_sum;

    // input register, loaded on every accepted beat
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quad <= i_quad;
        end
    end

    // sample masking and per-channel quad sums
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 3; c++) begin
                n_masked[p][c] = i_wide ? r_quad[p][c]
                                        : {{(SAMPLE_W-8){1'b0}}, r_quad[p][c][7:0]};
                o_ops.luma[p][c] = {2'b00, n_masked[p][c]};
            end
        end
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = {2'b00, n_masked[0][c]} + {2'b00, n_masked[1][c]}
                     + {2'b00, n_masked[2][c]} + {2'b00, n_masked[3][c]};
            o_ops.chroma[c] = i_wide ? n_sum[c] : {2'b00, n_sum[c][OP_W-1:2]};
        end
    end

endmodule
`default_nettype wire

### design/yuvq_weigh.sv
`default_nettype none
module yuvq_weigh (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic                      i_wide,
    input  wire logic                      i_chroma,
    input  wire logic [2:0][yuvq_pkg::OP_W-1:0] i_rgb,
    input  wire yuvq_pkg::t_coef_row       i_coef,
    output logic [yuvq_pkg::PIX_W-1:0]     o_byte
);
    import yuvq_pkg::*;

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  n_shr;
    logic signed [ACC_W-1:0]  n_val;
    logic [4:0]               n_sh;

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= $signed({1'b0, i_rgb[c]}) * $signed(i_coef[c]);
            end
        end
    end

    // round, floor shift, offset and clip to a byte
    always_comb begin
        n_acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2])
              + ACC_W'(32768);
        unique case ({i_chroma, i_wide})
            2'b01:   n_sh = 5'd18;
            2'b11:   n_sh = 5'd20;
            default: n_sh = 5'd16;
        endcase
        n_shr = n_acc >>> n_sh;
        n_val = i_chroma ? n_shr + ACC_W'(128) : n_shr;
        if (n_val[ACC_W-1]) begin
            o_byte = '0;
        end else if (|n_val[ACC_W-2:PIX_W]) begin
            o_byte = '1;
        end else begin
            o_byte = n_val[PIX_W-1:0];
        end
    end

endmodule
`default_nettype wire

### design/rgb_to_yuv420_quad_converter_top.sv
// throughput: one quad per cycle; input, product and result registers form
// a three-stage pipeline that stalls only while the result register is full
// and not taken
// reset: synchronous active low, clears stage valids, matrix_select to 1
// and wide_input to 0
`default_nettype none
module rgb_to_yuv420_quad_converter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_red_top_left,
    input  wire logic [15:0] i_green_top_left,
    input  wire logic [15:0] i_blue_top_left,
    input  wire logic [15:0] i_red_top_right,
    input  wire logic [15:0] i_green_top_right,
    input  wire logic [15:0] i_blue_top_right,
    input  wire logic [15:0] i_red_bottom_left,
    input  wire logic [15:0] i_green_bottom_left,
    input  wire logic [15:0] i_blue_bottom_left,
    input  wire logic [15:0] i_red_bottom_right,
    input  wire logic [15:0] i_green_bottom_right,
    input  wire logic [15:0] i_blue_bottom_right,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_luma_top_left,
    output logic [7:0]       o_luma_top_right,
    output logic [7:0]       o_luma_bottom_left,
    output logic [7:0]       o_luma_bottom_right,
    output logic [7:0]       o_chroma_u,
    output logic [7:0]       o_chroma_v,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [yuvq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        i_cfg_data
);
    import yuvq_pkg::*;

    logic r_matrix_select;
    logic r_wide_input;
    logic r_v1, r_v2, r_v3;
    logic n_en1, n_en2, n_load;
    t_quad     n_quad;
    t_quad_ops n_ops;
    t_matrix   n_matrix;
    logic [5:0][PIX_W-1:0] n_bytes;
    logic [5:0][PIX_W-1:0] r_bytes;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_select <= 1'b1;
            r_wide_input    <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MATRIX_SELECT) begin
                r_matrix_select <= i_cfg_data;
            end
            if (i_cfg_index == CFG_WIDE_INPUT) begin
                r_wide_input <= i_cfg_data;
            end
        end
    end

    // pipeline advance
    assign n_en2   = !r_v3 || i_ready;
    assign n_en1   = !r_v2 || n_en2;
    assign o_ready = !r_v1 || n_en1;
    assign n_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (n_en1) begin
                r_v2 <= r_v1;
            end
            if (n_en2) begin
                r_v3 <= r_v2;
            end
        end
    end

    // input beat as a quad of pixels, r/g/b per pixel
    assign n_quad = '{
        '{i_blue_bottom_right, i_green_bottom_right, i_red_bottom_right},
        '{i_blue_bottom_left,  i_green_bottom_left,  i_red_bottom_left},
        '{i_blue_top_right,    i_green_top_right,    i_red_top_right},
        '{i_blue_top_left,     i_green_top_left,     i_red_top_left}
    };

    yuvq_front u_front (
        .i_clk  (i_clk),
        .i_load (n_load),
        .i_wide (r_wide_input),
        .i_quad (n_quad),
        .o_ops  (n_ops)
    );

    assign n_matrix = r_matrix_select ? MATRIX_709 : MATRIX_601;

    // four luma units and two chroma units
    for (genvar p = 0; p < 4; p++) begin : g_luma
        yuvq_weigh u_luma (
            .i_clk    (i_clk),
            .i_en     (n_en1),
            .i_wide   (r_wide_input),
            .i_chroma (1'b0),
            .i_rgb    (n_ops.luma[p]),
            .i_coef   (n_matrix[0]),
            .o_byte   (n_bytes[p])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_chroma
        yuvq_weigh u_chroma (
            .i_clk    (i_clk),
            .i_en     (n_en1),
            .i_wide   (r_wide_input),
            .i_chroma (1'b1),
            .i_rgb    (n_ops.chroma),
            .i_coef   (n_matrix[k + 1]),
            .o_byte   (n_bytes[k + 4])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (n_en2) begin
            r_bytes <= n_bytes;
        end
    end

    assign o_valid             = r_v3;
    assign o_luma_top_left     = r_bytes[0];
    assign o_luma_top_right    = r_bytes[1];
    assign o_luma_bottom_left  = r_bytes[2];
    assign o_luma_bottom_right = r_bytes[3];
    assign o_chroma_u          = r_bytes[4];
    assign o_chroma_v          = r_bytes[5];

endmodule
`default_nettype wire
